### design/ssc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the stepping slider controller.
// Used by ssc_core and the stepping_slider_controller top level; depends on nothing.
package ssc_pkg;

    // Configuration register indexes and port widths.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STOP_ANGLE = 1'b0,
        REG_MOVE_MS    = 1'b1
    } ssc_reg_t;

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    // Register reset values.
    localparam logic [7:0]  STOP_ANGLE_RESET = 8'd93;
    localparam logic [11:0] MOVE_MS_RESET    = 12'd400;

    // Settings in quarter-detent counts.
    localparam logic [8:0] INTERVAL_LO    = 9'd4;
    localparam logic [8:0] INTERVAL_HI    = 9'd396;
    localparam logic [8:0] INTERVAL_RESET = 9'd4;
    localparam logic [5:0] DISTANCE_LO    = 6'd4;
    localparam logic [5:0] DISTANCE_HI    = 6'd40;
    localparam logic [5:0] DISTANCE_RESET = 6'd4;
    localparam logic [2:0] DIRECTION_LO   = 3'd0;
    localparam logic [2:0] DIRECTION_HI   = 3'd4;

    // Timing, angle and span constants.
    localparam logic [7:0]  LOCKOUT_MS   = 8'd250;
    localparam logic [16:0] MS_PER_S     = 17'd1000;
    localparam logic [16:0] PHASE_MS_MAX = 17'h1FFFF;
    localparam logic [7:0]  ANGLE_MAX    = 8'd180;
    localparam logic [4:0]  SPAN_BASE    = 5'd5;

    // Setting selection codes.
    localparam logic [1:0] SEL_INTERVAL  = 2'd0;
    localparam logic [1:0] SEL_DISTANCE  = 2'd1;
    localparam logic [1:0] SEL_DIRECTION = 2'd2;
    localparam logic [1:0] SEL_STRAY     = 2'd3;

    // Quadrature transitions, coded as {previous pins, current pins}.
    localparam logic [3:0] QUAD_UP_0   = 4'b1101;
    localparam logic [3:0] QUAD_UP_1   = 4'b0100;
    localparam logic [3:0] QUAD_UP_2   = 4'b0010;
    localparam logic [3:0] QUAD_UP_3   = 4'b1011;
    localparam logic [3:0] QUAD_DOWN_0 = 4'b1110;
    localparam logic [3:0] QUAD_DOWN_1 = 4'b0111;
    localparam logic [3:0] QUAD_DOWN_2 = 4'b0001;
    localparam logic [3:0] QUAD_DOWN_3 = 4'b1000;

    // Run sequencer phases.
    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_DRIVE = 2'd1,
        PHASE_WAIT  = 2'd2
    } ssc_phase_t;

    // One input sample.
    typedef struct packed {
        logic enc_a;
        logic enc_b;
        logic button_down;
        logic run_switch;
        logic ms_tick;
    } ssc_item_t;

    // One result.
    typedef struct packed {
        logic [7:0] servo_angle;
        logic [1:0] selected;
        logic [6:0] shown_value;
        logic       running;
    } ssc_result_t;

    // Encoder step direction.
    typedef struct packed {
        logic up;
        logic down;
    } ssc_step_t;

    // Decode one quadrature transition into an up or down step.
    function automatic ssc_step_t quad_decode(input logic [3:0] pair);
        ssc_step_t s;
        s = '0;
        unique case (pair)
            QUAD_UP_0, QUAD_UP_1, QUAD_UP_2, QUAD_UP_3:         s.up = 1'b1;
            QUAD_DOWN_0, QUAD_DOWN_1, QUAD_DOWN_2, QUAD_DOWN_3: s.down = 1'b1;
            default:                                           s = '0;
        endcase
        return s;
    endfunction

    // Clamp a signed angle into the servo range.
    function automatic logic [7:0] clamp_angle(input logic signed [9:0] a);
        logic [7:0] r;
        if (a < 0)
        begin
            r = 8'd0;
        end
        else if (a > $signed({2'b00, ANGLE_MAX}))
        begin
            r = ANGLE_MAX;
        end
        else
        begin
            r = a[7:0];
        end
        return r;
    endfunction

endpackage

### design/ssc_core.sv
`timescale 1ns / 1ps
// Per-sample state update of the stepping slider controller: encoder, button,
// run sequencer and configuration registers. Depends on ssc_pkg.
module ssc_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_accept,
    input  ssc_pkg::ssc_item_t                 item,
    input  logic                               cfg_we,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ssc_pkg::ssc_result_t               result
);
    import ssc_pkg::*;

    logic [7:0]  stop_angle_reg;
    logic [11:0] move_ms_reg;
    logic [1:0]  last_pins_reg, last_pins_next;
    logic [8:0]  interval_reg, interval_next;
    logic [5:0]  distance_reg, distance_next;
    logic [2:0]  direction_reg, direction_next;
    logic [1:0]  selection_reg, selection_next;
    logic [7:0]  lockout_reg, lockout_next;
    ssc_phase_t  phase_reg, phase_next;
    logic [16:0] phase_ms_reg, phase_ms_next;
    logic [7:0]  servo_reg, servo_next;

    logic [1:0]        pins;
    ssc_step_t         step;
    logic [7:0]        lockout_dec;
    logic [16:0]       phase_ms_inc;
    logic [16:0]       wait_ms;
    logic              move_done;
    logic              wait_done;
    logic              lockout_clear;
    logic              start_step;
    logic              end_drive;
    logic              sel_advance;
    logic [4:0]        span;
    logic signed [9:0] drive_raw;
    logic [6:0]        shown;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_angle_reg <= STOP_ANGLE_RESET;
            move_ms_reg    <= MOVE_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (ssc_reg_t'(cfg_index))
                REG_STOP_ANGLE: stop_angle_reg <= cfg_data[7:0];
                REG_MOVE_MS:    move_ms_reg    <= cfg_data;
                default:        stop_angle_reg <= stop_angle_reg;
            endcase
        end
    end

    // Encoder: a valid transition nudges the selected setting, saturating.
    always_comb
    begin
        pins           = {item.enc_a, item.enc_b};
        step           = quad_decode({last_pins_reg, pins});
        last_pins_next = pins;
        interval_next  = interval_reg;
        distance_next  = distance_reg;
        direction_next = direction_reg;
        unique case (selection_reg)
            SEL_INTERVAL:
            begin
                if (step.up)
                    interval_next = (interval_reg < INTERVAL_HI) ? interval_reg + 9'd1
                                                                 : INTERVAL_HI;
                else if (step.down)
                    interval_next = (interval_reg > INTERVAL_LO) ? interval_reg - 9'd1
                                                                 : INTERVAL_LO;
            end
            SEL_DISTANCE:
            begin
                if (step.up)
                    distance_next = (distance_reg < DISTANCE_HI) ? distance_reg + 6'd1
                                                                 : DISTANCE_HI;
                else if (step.down)
                    distance_next = (distance_reg > DISTANCE_LO) ? distance_reg - 6'd1
                                                                 : DISTANCE_LO;
            end
            SEL_DIRECTION:
            begin
                if (step.up)
                    direction_next = (direction_reg < DIRECTION_HI) ? direction_reg + 3'd1
                                                                    : DIRECTION_HI;
                else if (step.down)
                    direction_next = (direction_reg > DIRECTION_LO) ? direction_reg - 3'd1
                                                                    : DIRECTION_LO;
            end
            default:
            begin
                interval_next = interval_reg;
            end
        endcase
    end

    // Millisecond counters, advanced before the sequencer looks at them.
    always_comb
    begin
        lockout_dec   = (lockout_reg != 8'd0 && item.ms_tick) ? lockout_reg - 8'd1
                                                              : lockout_reg;
        phase_ms_inc  = phase_ms_reg;
        if ((phase_reg == PHASE_DRIVE || phase_reg == PHASE_WAIT) && item.ms_tick
            && phase_ms_reg != PHASE_MS_MAX)
        begin
            phase_ms_inc = phase_ms_reg + 17'd1;
        end
        wait_ms       = 17'(interval_next[8:2]) * MS_PER_S;
        move_done     = phase_ms_inc >= {5'd0, move_ms_reg};
        wait_done     = phase_ms_inc >= wait_ms;
        lockout_clear = lockout_dec == 8'd0;
    end

    // Sequencer next phase.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PHASE_IDLE:
            begin
                if (lockout_clear && item.run_switch)
                    phase_next = PHASE_DRIVE;
            end
            PHASE_DRIVE:
            begin
                if (move_done)
                    phase_next = PHASE_WAIT;
            end
            PHASE_WAIT:
            begin
                if (wait_done)
                    phase_next = item.run_switch ? PHASE_DRIVE : PHASE_IDLE;
            end
            default:
            begin
                phase_next = PHASE_IDLE;
            end
        endcase
    end

    // Sequencer actions: step start, drive end and selection advance.
    always_comb
    begin
        start_step  = ((phase_reg == PHASE_IDLE) && lockout_clear && item.run_switch)
                   || ((phase_reg == PHASE_WAIT) && wait_done && item.run_switch);
        end_drive   = (phase_reg == PHASE_DRIVE) && move_done;
        sel_advance = (phase_reg == PHASE_IDLE) && lockout_clear && !item.run_switch
                   && item.button_down;

        span = SPAN_BASE + {1'b0, distance_next[5:2]};
        if (direction_next[2])
            drive_raw = $signed({2'b00, stop_angle_reg}) - $signed({5'd0, span});
        else
            drive_raw = $signed({2'b00, stop_angle_reg}) - 10'sd1
                      + $signed({5'd0, span});

        if (start_step)
            servo_next = clamp_angle(drive_raw);
        else if (end_drive)
            servo_next = clamp_angle($signed({2'b00, stop_angle_reg}));
        else
            servo_next = servo_reg;

        phase_ms_next = start_step ? 17'd0 : phase_ms_inc;
        lockout_next  = sel_advance ? LOCKOUT_MS : lockout_dec;

        selection_next = selection_reg;
        if (sel_advance)
        begin
            unique case (selection_reg)
                SEL_INTERVAL:  selection_next = SEL_DISTANCE;
                SEL_DISTANCE:  selection_next = SEL_DIRECTION;
                SEL_DIRECTION: selection_next = SEL_INTERVAL;
                SEL_STRAY:     selection_next = SEL_DISTANCE;
                default:       selection_next = SEL_INTERVAL;
            endcase
        end
    end

    // State registers, updated once per accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pins_reg <= 2'd0;
            interval_reg  <= INTERVAL_RESET;
            distance_reg  <= DISTANCE_RESET;
            direction_reg <= 3'd0;
            selection_reg <= SEL_INTERVAL;
            lockout_reg   <= 8'd0;
            phase_reg     <= PHASE_IDLE;
            phase_ms_reg  <= 17'd0;
            servo_reg     <= STOP_ANGLE_RESET;
        end
        else if (item_accept)
        begin
            last_pins_reg <= last_pins_next;
            interval_reg  <= interval_next;
            distance_reg  <= distance_next;
            direction_reg <= direction_next;
            selection_reg <= selection_next;
            lockout_reg   <= lockout_next;
            phase_reg     <= phase_next;
            phase_ms_reg  <= phase_ms_next;
            servo_reg     <= servo_next;
        end
    end

    // Result from the updated state.
    always_comb
    begin
        unique case (selection_next)
            SEL_INTERVAL:  shown = interval_next[8:2];
            SEL_DISTANCE:  shown = {3'd0, distance_next[5:2]};
            SEL_DIRECTION: shown = {6'd0, direction_next[2]};
            default:       shown = 7'd0;
        endcase
        result.servo_angle = servo_next;
        result.selected    = selection_next;
        result.shown_value = shown;
        result.running     = phase_next != PHASE_IDLE;
    end

endmodule

### design/stepping_slider_controller.sv
`timescale 1ns / 1ps
// Top level of the stepping slider controller: stream ports, configuration port
// and the output register with skid stage. Depends on ssc_pkg and ssc_core.
//
// The block takes one pin sample per clock while s_axis_tready is high and
// returns one result per sample, registered in the output register or, while the
// output is stalled, in the skid stage. The sustained rate is one transaction per
// cycle while the output is not stalled. A skid stage behind the output register
// keeps the input side ready while one result waits on a stalled output.
// Configuration is written through its own channel, which is always ready, and
// should be changed only while no sample is in flight.
module stepping_slider_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // enc_a, enc_b, button_down, run_switch, ms_tick, zero fill
    input  logic [ssc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // servo_angle[7:0], shown_value[14:8], running[15]
    output logic [ssc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // selected[1:0]
    output logic [ssc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ssc_pkg::*;

    ssc_item_t   item;
    ssc_result_t result;
    logic        in_accept;

    logic        out_valid_reg;
    ssc_result_t out_data_reg;
    logic        skid_valid_reg;
    ssc_result_t skid_data_reg;

    // Unpack the sample.
    always_comb
    begin
        item.enc_a       = s_axis_tdata[0];
        item.enc_b       = s_axis_tdata[1];
        item.button_down = s_axis_tdata[2];
        item.run_switch  = s_axis_tdata[3];
        item.ms_tick     = s_axis_tdata[4];
    end

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    ssc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (in_accept),
        .item        (item),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result      (result)
    );

    // Output register with skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_axis_tready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_axis_tready || !out_valid_reg)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (in_accept)
        begin
            skid_data_reg <= result;
        end
    end

    // Pack the result transaction.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.running, out_data_reg.shown_value,
                            out_data_reg.servo_angle};
    assign m_axis_tuser  = out_data_reg.selected;

endmodule

### design/ssc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the stepping slider controller, bound to the top level.
// Depends on ssc_pkg and stepping_slider_controller.
module ssc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [ssc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [ssc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input logic [ssc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [ssc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input logic [ssc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ssc_pkg::*;

    // The selection never reaches the stray code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != SEL_STRAY)
        else $error("selected setting holds the stray code");

    // The servo command stays inside the servo range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] <= ANGLE_MAX)
        else $error("servo angle out of range");

    // The shown value never exceeds two digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:8] <= 7'd99)
        else $error("shown value out of range");

    // A stalled result transaction holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind stepping_slider_controller ssc_checker u_ssc_checker (.*);
